### rtl/residual_group_rms_normalize_macros.svh
`ifndef RESIDUAL_GROUP_RMS_NORMALIZE_MACROS_SVH
`define RESIDUAL_GROUP_RMS_NORMALIZE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define RGRN_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Trigger in one cycle implies the consequence in the next.
`define RGRN_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

### rtl/rgrn_pkg.sv
package rgrn_pkg;

	localparam int RES_W      = 32;
	localparam int SQ_W       = 64;
	localparam int FACT_W     = 48;
	localparam int N_W        = 7;
	localparam int MS_W       = 96;
	localparam int RAD_W      = 98;
	localparam int ROOT_W     = 49;
	localparam int SREM_W     = 53;
	localparam int QD_W       = 72;
	localparam int STEP_W     = 7;
	localparam int DIV_STEPS  = 96;
	localparam int SQRT_STEPS = 49;
	localparam int QDIV_STEPS = 72;
	localparam int CFG_IDX_W  = 3;

	localparam logic [FACT_W-1:0] FACT_MAX = {FACT_W{1'b1}};
	localparam logic [7:0] OUT_MAX = 8'd127;

	localparam logic [CFG_IDX_W-1:0] REG_STATE_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROJ_SHIFT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON     = 3'd4;

	typedef enum logic [3:0] {
		S_LOAD,
		S_DRAIN,
		S_DIV,
		S_SQ_INIT,
		S_SQRT,
		S_QD_INIT,
		S_QDIV,
		S_FIN,
		S_RD,
		S_MUL,
		S_SUM,
		S_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic start_div;
		logic div_step;
		logic start_sqrt;
		logic sqrt_step;
		logic start_qdiv;
		logic qdiv_step;
		logic fin_factor;
		logic em_mul;
		logic em_sum;
		logic em_load;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic row_full;
		logic out_free;
		logic em_last;
	} sts_t;

endpackage

### rtl/rgrn_ram.sv
module rgrn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/rgrn_ctrl.sv
module rgrn_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 row_end,
	output logic                 in_stall,
	input  rgrn_pkg::sts_t       sts,
	output rgrn_pkg::cmd_t       cmd
);

	rgrn_pkg::state_t state_q, state_d;
	logic [rgrn_pkg::STEP_W-1:0] cnt_q;
	logic last_step;

	always_comb begin
		last_step = 1'b0;
		case (state_q)
			rgrn_pkg::S_DIV:  last_step = cnt_q == rgrn_pkg::STEP_W'(rgrn_pkg::DIV_STEPS - 1);
			rgrn_pkg::S_SQRT: last_step = cnt_q == rgrn_pkg::STEP_W'(rgrn_pkg::SQRT_STEPS - 1);
			rgrn_pkg::S_QDIV: last_step = cnt_q == rgrn_pkg::STEP_W'(rgrn_pkg::QDIV_STEPS - 1);
			default:          last_step = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rgrn_pkg::S_LOAD: begin
				if (in_valid && (row_end || sts.row_full)) state_d = rgrn_pkg::S_DRAIN;
			end
			rgrn_pkg::S_DRAIN: begin
				if (!sts.pipe_busy) state_d = rgrn_pkg::S_DIV;
			end
			rgrn_pkg::S_DIV: begin
				if (last_step) state_d = rgrn_pkg::S_SQ_INIT;
			end
			rgrn_pkg::S_SQ_INIT: state_d = rgrn_pkg::S_SQRT;
			rgrn_pkg::S_SQRT: begin
				if (last_step) state_d = rgrn_pkg::S_QD_INIT;
			end
			rgrn_pkg::S_QD_INIT: state_d = rgrn_pkg::S_QDIV;
			rgrn_pkg::S_QDIV: begin
				if (last_step) state_d = rgrn_pkg::S_FIN;
			end
			rgrn_pkg::S_FIN: state_d = rgrn_pkg::S_RD;
			rgrn_pkg::S_RD:  state_d = rgrn_pkg::S_MUL;
			rgrn_pkg::S_MUL: state_d = rgrn_pkg::S_SUM;
			rgrn_pkg::S_SUM: state_d = rgrn_pkg::S_OUT;
			rgrn_pkg::S_OUT: begin
				if (sts.out_free) state_d = sts.em_last ? rgrn_pkg::S_LOAD : rgrn_pkg::S_RD;
			end
			default: state_d = rgrn_pkg::S_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			rgrn_pkg::S_LOAD: begin
				in_stall = 1'b0;
				cmd.accept = in_valid;
			end
			rgrn_pkg::S_DRAIN:   cmd.start_div = !sts.pipe_busy;
			rgrn_pkg::S_DIV:     cmd.div_step = 1'b1;
			rgrn_pkg::S_SQ_INIT: cmd.start_sqrt = 1'b1;
			rgrn_pkg::S_SQRT:    cmd.sqrt_step = 1'b1;
			rgrn_pkg::S_QD_INIT: cmd.start_qdiv = 1'b1;
			rgrn_pkg::S_QDIV:    cmd.qdiv_step = 1'b1;
			rgrn_pkg::S_FIN:     cmd.fin_factor = 1'b1;
			rgrn_pkg::S_MUL:     cmd.em_mul = 1'b1;
			rgrn_pkg::S_SUM:     cmd.em_sum = 1'b1;
			rgrn_pkg::S_OUT:     cmd.em_load = sts.out_free;
			default:             cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgrn_pkg::S_LOAD;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

### rtl/rgrn_datapath.sv
module rgrn_datapath #(
	parameter int MAX_ROWS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [rgrn_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic signed [7:0]                 state_value,
	input  logic signed [31:0]                model_output,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic signed [7:0]                 next_value,
	output logic                              clipped,
	output logic                              result_last,
	input  rgrn_pkg::cmd_t                    cmd,
	output rgrn_pkg::sts_t                    sts
);

	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam int AW = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;

	logic signed [5:0] state_gain_q;
	logic signed [1:0] output_gain_q;
	logic [4:0]        proj_shift_q;
	logic [31:0]       target_q;
	logic [31:0]       eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_gain_q  <= 6'sd1;
			output_gain_q <= 2'sd1;
			proj_shift_q  <= '0;
			target_q      <= 32'd65536;
			eps_q         <= 32'd4295;
		end else if (cfg_valid) begin
			case (cfg_index)
				rgrn_pkg::REG_STATE_GAIN:  state_gain_q  <= cfg_data[5:0];
				rgrn_pkg::REG_OUTPUT_GAIN: output_gain_q <= cfg_data[1:0];
				rgrn_pkg::REG_PROJ_SHIFT:  proj_shift_q  <= cfg_data[4:0];
				rgrn_pkg::REG_TARGET:      target_q      <= cfg_data;
				rgrn_pkg::REG_EPSILON:     eps_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// residual formation
	logic signed [33:0] proj_prod;
	logic               proj_neg;
	logic [33:0]        proj_mag;
	logic [34:0]        proj_rnd;
	logic signed [35:0] proj_val;
	logic signed [35:0] state_term;
	logic signed [35:0] res_sum;
	logic signed [31:0] res_sat;

	always_comb begin
		proj_prod = $signed({{2{model_output[31]}}, model_output})
			* $signed({{32{output_gain_q[1]}}, output_gain_q});
		proj_neg = proj_prod[33];
		proj_mag = proj_neg ? 34'(-proj_prod) : 34'(proj_prod);
		proj_rnd = 35'(proj_mag);
		if (proj_shift_q != '0) begin
			proj_rnd = (proj_rnd + (35'(1) << (proj_shift_q - 5'd1))) >> proj_shift_q;
		end
		proj_val = proj_neg ? -$signed({1'b0, proj_rnd}) : $signed({1'b0, proj_rnd});
		state_term = 36'(state_value * state_gain_q);
		res_sum = state_term + proj_val;
		if (res_sum > 36'sh07FFFFFFF) res_sat = 32'sh7FFFFFFF;
		else if (res_sum < -36'sh080000000) res_sat = 32'sh80000000;
		else res_sat = res_sum[31:0];
	end

	logic               v_s1, v_s2;
	logic signed [31:0] res_s1;
	logic [AW-1:0]      idx_s1;
	logic [63:0]        sq_s2;
	logic [CW-1:0]      count_q;
	logic [64:0]        sum_add;
	logic [63:0]        sum_q;

	assign sum_add = 65'(sum_q) + 65'(sq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			count_q <= '0;
			sum_q   <= '0;
		end else begin
			v_s1 <= cmd.accept;
			v_s2 <= v_s1;
			if (cmd.accept) count_q <= count_q + 1'b1;
			else if (cmd.start_div) count_q <= '0;
			if (cmd.start_div) sum_q <= '0;
			else if (v_s2) sum_q <= sum_add[64] ? {64{1'b1}} : sum_add[63:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_s1 <= res_sat;
			idx_s1 <= count_q[AW-1:0];
		end
		if (v_s1) sq_s2 <= 64'(res_s1 * res_s1);
	end

	logic [AW-1:0]  rd_idx_q;
	logic [31:0]    rd_data;

	rgrn_ram #(.WIDTH(rgrn_pkg::RES_W), .DEPTH(MAX_ROWS)) u_store (
		.clk   (clk),
		.we    (v_s1),
		.waddr (idx_s1),
		.wdata (res_s1),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	// mean square: floor(sum * 2^32 / n)
	logic [rgrn_pkg::N_W-1:0]  n_q;
	logic [rgrn_pkg::MS_W-1:0] dq_q;
	logic [rgrn_pkg::N_W-1:0]  drem_q;
	logic [rgrn_pkg::N_W:0]    drem_t;
	logic                      dbit;

	assign drem_t = {drem_q, dq_q[rgrn_pkg::MS_W-1]};
	assign dbit   = drem_t >= {1'b0, n_q};

	// integer square root
	logic [rgrn_pkg::RAD_W-1:0]  rad_q;
	logic [rgrn_pkg::SREM_W-1:0] srem_q;
	logic [rgrn_pkg::ROOT_W-1:0] root_q;
	logic [rgrn_pkg::SREM_W-1:0] srem_t, strial;
	logic                        sbit;

	assign srem_t = {srem_q[rgrn_pkg::SREM_W-3:0], rad_q[rgrn_pkg::RAD_W-1 -: 2]};
	assign strial = {2'b00, root_q, 2'b01};
	assign sbit   = srem_t >= strial;

	// target * 2^40 / root
	logic [rgrn_pkg::FACT_W-1:0] rt_q;
	logic [rgrn_pkg::QD_W-1:0]   qd_q;
	logic [rgrn_pkg::FACT_W-1:0] qrem_q;
	logic [rgrn_pkg::FACT_W:0]   qrem_t;
	logic                        qbit;
	logic [rgrn_pkg::FACT_W-1:0] factor_q;

	assign qrem_t = {qrem_q, qd_q[rgrn_pkg::QD_W-1]};
	assign qbit   = qrem_t >= {1'b0, rt_q};

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			n_q    <= rgrn_pkg::N_W'(count_q);
			dq_q   <= {sum_q, 32'd0};
			drem_q <= '0;
		end else if (cmd.div_step) begin
			drem_q <= dbit ? rgrn_pkg::N_W'(drem_t - {1'b0, n_q}) : drem_t[rgrn_pkg::N_W-1:0];
			dq_q   <= {dq_q[rgrn_pkg::MS_W-2:0], dbit};
		end
		if (cmd.start_sqrt) begin
			rad_q  <= rgrn_pkg::RAD_W'(dq_q) + rgrn_pkg::RAD_W'(eps_q);
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			srem_q <= sbit ? srem_t - strial : srem_t;
			root_q <= {root_q[rgrn_pkg::ROOT_W-2:0], sbit};
			rad_q  <= {rad_q[rgrn_pkg::RAD_W-3:0], 2'b00};
		end
		if (cmd.start_qdiv) begin
			rt_q   <= root_q[rgrn_pkg::ROOT_W-1] ? rgrn_pkg::FACT_MAX
				: root_q[rgrn_pkg::FACT_W-1:0];
			qd_q   <= {target_q, 40'd0};
			qrem_q <= '0;
		end else if (cmd.qdiv_step) begin
			qrem_q <= qbit ? rgrn_pkg::FACT_W'(qrem_t - {1'b0, rt_q})
				: qrem_t[rgrn_pkg::FACT_W-1:0];
			qd_q   <= {qd_q[rgrn_pkg::QD_W-2:0], qbit};
		end
		if (cmd.fin_factor) begin
			if (rt_q == '0 || qd_q[rgrn_pkg::QD_W-1:rgrn_pkg::FACT_W] != '0)
				factor_q <= rgrn_pkg::FACT_MAX;
			else
				factor_q <= qd_q[rgrn_pkg::FACT_W-1:0];
		end
	end

	// emission
	logic [31:0] em_mag;
	logic [55:0] pp0_q, pp1_q;
	logic        neg_q, neg_s2;
	logic [79:0] prod_q;
	logic [39:0] whole;
	logic [39:0] frac;
	logic        round_up;
	logic [40:0] whole_r;
	logic        clip;
	logic [7:0]  mag8;
	logic        em_last;

	assign em_mag = rd_data[31] ? 32'(-rd_data) : rd_data;

	always_comb begin
		whole    = prod_q[79:40];
		frac     = prod_q[39:0];
		round_up = frac > 40'h8000000000 || (frac == 40'h8000000000 && whole[0]);
		whole_r  = 41'(whole) + 41'(round_up);
		clip     = whole_r > 41'(rgrn_pkg::OUT_MAX);
		mag8     = clip ? rgrn_pkg::OUT_MAX : whole_r[7:0];
		em_last  = rgrn_pkg::N_W'(rd_idx_q) == n_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.em_mul) begin
			pp0_q <= em_mag * factor_q[23:0];
			pp1_q <= em_mag * factor_q[47:24];
			neg_q <= rd_data[31];
		end
		if (cmd.em_sum) begin
			prod_q <= 80'(pp0_q) + (80'(pp1_q) << 24);
			neg_s2 <= neg_q;
		end
		if (cmd.em_load) begin
			next_value  <= neg_s2 ? -$signed(mag8) : $signed(mag8);
			clipped     <= clip;
			result_last <= em_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			rd_idx_q  <= '0;
		end else begin
			if (cmd.em_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (cmd.fin_factor) rd_idx_q <= '0;
			else if (cmd.em_load) rd_idx_q <= rd_idx_q + 1'b1;
		end
	end

	assign sts.pipe_busy = v_s1 | v_s2;
	assign sts.row_full  = count_q == CW'(MAX_ROWS - 1);
	assign sts.out_free  = !out_valid || !out_stall;
	assign sts.em_last   = em_last;

endmodule

### rtl/residual_group_rms_normalize.sv
// Residual group RMS normalization over int8 rows.
// Input channel (in_valid/in_stall): one element per transaction, state_value,
// model_output and row_end. Elements are taken one per cycle while a row loads.
// The row closes on row_end or when MAX_ROWS elements are held.
// Row close: pipeline drain, mean-square divider, square root, factor divider
// and three setup steps, during all of which in_stall is high.
// Output channel (out_valid/out_stall): one transaction per stored element,
// result_last on the last. Each result passes through store read, two
// multiply stages and rounding; a stall holds the output register and the
// emission waits on it. Loading of the next row starts as soon as the last
// result is in the output register.
// Config channel (cfg_valid/cfg_ready): always ready; write only when idle.
// Reset (arst_n low) returns registers to defaults and empties the row.
module residual_group_rms_normalize #(
	parameter int MAX_ROWS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [7:0]    state_value,
	input  logic signed [31:0]   model_output,
	input  logic                 row_end,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [7:0]    next_value,
	output logic                 clipped,
	output logic                 result_last
);

	`include "residual_group_rms_normalize_macros.svh"

	rgrn_pkg::cmd_t cmd;
	rgrn_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	rgrn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.row_end  (row_end),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rgrn_datapath #(.MAX_ROWS(MAX_ROWS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.state_value  (state_value),
		.model_output (model_output),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.next_value   (next_value),
		.clipped      (clipped),
		.result_last  (result_last),
		.cmd          (cmd),
		.sts          (sts)
	);

	`RGRN_ASSERT(a_load_into_free, !cmd.em_load || sts.out_free, "result loaded over a pending one")
	`RGRN_ASSERT_NEXT(a_last_shown, cmd.em_load && sts.em_last, out_valid && result_last, "row end not flagged")
	`RGRN_ASSERT(a_no_accept_in_flight, !(cmd.accept && cmd.start_div), "accept during row close")

endmodule
